[rtl/rcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter: shared package
// Types, register codes and fixed constants used by the filter modules.
// ----------------------------------------------------------------------------
package rcf_pkg;

	// One pixel packed as blue in the low byte, then green, then red.
	localparam int PIX_BITS   = 24;
	localparam int CH_BITS    = 8;
	localparam int NUM_TAPS   = 9;
	localparam int NUM_CH     = 3;
	localparam int DIM_BITS   = 12;
	localparam int HEIGHT_CAP = 2048;
	// Kernel coefficients are signed with 8 fraction bits; three fill a row.
	localparam int COEF_BITS  = 16;
	localparam int ROW_BITS   = 3 * COEF_BITS;
	localparam int SCALE_BITS = 24;
	localparam int BIAS_BITS  = 17;
	localparam int IDX_BITS   = 3;

	typedef logic [PIX_BITS-1:0] pixel_t;

	// Register indexes of the configuration port.
	typedef enum logic [IDX_BITS-1:0] {
		REG_KERNEL_TOP    = 3'd0,
		REG_KERNEL_MIDDLE = 3'd1,
		REG_KERNEL_BOTTOM = 3'd2,
		REG_SCALE         = 3'd3,
		REG_BIAS          = 3'd4,
		REG_FRAME_WIDTH   = 3'd5,
		REG_FRAME_HEIGHT  = 3'd6
	} cfg_reg_t;

	// Window sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} win_state_t;

	// Window handed to the filter lanes.
	typedef struct packed {
		logic                         valid;
		logic                         last;
		logic [NUM_TAPS-1:0][PIX_BITS-1:0] taps;
	} launch_t;

endpackage

[rtl/rcf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter: channel interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface rcf_pix_if;
	logic       valid;
	logic       ready;
	logic       is_flush;
	logic [7:0] pixel_blue;
	logic [7:0] pixel_green;
	logic [7:0] pixel_red;

	modport source(output valid, is_flush, pixel_blue, pixel_green, pixel_red, input ready);
	modport sink(input valid, is_flush, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

interface rcf_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic       frame_last;

	modport source(output valid, out_blue, out_green, out_red, frame_last, input ready);
	modport sink(input valid, out_blue, out_green, out_red, frame_last, output ready);
endinterface

interface rcf_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[rtl/rcf_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter: line stores and window
// Keeps the two line stores, the 3x3 window and the frame counters, and
// hands each finished window to the filter lanes.
// ----------------------------------------------------------------------------
module rcf_window #(
	parameter  int MAX_WIDTH = 2048,
	localparam int XW        = $clog2(MAX_WIDTH + 1),
	localparam int TW        = XW + 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      is_flush,
	input  rcf_pkg::pixel_t           pixel,
	input  logic                      restart_req,
	input  logic [XW-1:0]             eff_w,
	input  logic [11:0]               eff_h,
	input  logic [TW-1:0]             total,
	output logic                      busy,
	output rcf_pkg::launch_t          launch
);
	import rcf_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	win_state_t state_q, state_n;
	logic       upd;

	logic [CW-1:0] col_q;
	logic [11:0]   row_q;
	logic [TW-1:0] pos_q;
	logic [NUM_TAPS-1:0][PIX_BITS-1:0] win_q, win_n, taps;

	logic [CW-1:0] x_q, x_eff;
	pixel_t        bot_q, rd_up_q, rd_low_q, mid, top;
	logic          ign_q, tail, emit, last;

	pixel_t mem_upper [MAX_WIDTH];
	pixel_t mem_lower [MAX_WIDTH];

	// Column wraps to zero when it lies beyond the current width.
	assign tail  = (row_q >= eff_h);
	assign x_eff = (XW'(col_q) >= eff_w) ? '0 : col_q;

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_n = ST_UPDATE;
			ST_UPDATE: state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		busy = 1'b0;
		upd  = 1'b0;
		case (state_q)
			ST_IDLE:   busy = 1'b0;
			ST_UPDATE: begin
				busy = 1'b1;
				upd  = 1'b1;
			end
			default:   busy = 1'b0;
		endcase
	end

	// Capture the word and read both line stores at its column.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q      <= x_eff;
			bot_q    <= tail ? '0 : pixel;
			ign_q    <= !tail && is_flush;
			rd_up_q  <= mem_upper[x_eff];
			rd_low_q <= mem_lower[x_eff];
		end
	end

	// Rows above the frame read as zero.
	assign mid = (row_q != 12'd0) ? rd_low_q : '0;
	assign top = (row_q >= 12'd2) ? rd_up_q : '0;

	// Line store update: the lower row moves up, the new pixel goes in below.
	always_ff @(posedge clk) begin
		if (upd && !ign_q) begin
			mem_upper[x_q] <= mid;
			mem_lower[x_q] <= bot_q;
		end
	end

	// Window shift and the taps handed on.
	always_comb begin
		win_n = win_q;
		taps  = win_q;
		emit  = 1'b0;
		if (x_q == '0) begin
			// The previous row ends: its right column lies outside the frame.
			for (int r = 0; r < 3; r++) begin
				taps[r*3+0]  = win_q[r*3+1];
				taps[r*3+1]  = win_q[r*3+2];
				taps[r*3+2]  = '0;
				win_n[r*3+0] = '0;
				win_n[r*3+1] = '0;
			end
			emit = (row_q >= 12'd2);
		end else begin
			for (int r = 0; r < 3; r++) begin
				win_n[r*3+0] = win_q[r*3+1];
				win_n[r*3+1] = win_q[r*3+2];
			end
			emit = (row_q != 12'd0);
		end
		win_n[2] = top;
		win_n[5] = mid;
		win_n[8] = bot_q;
		if (x_q != '0) begin
			taps = win_n;
		end
	end

	assign last = ((TW+1)'(pos_q) + (TW+1)'(1)) >= (TW+1)'(total);

	assign launch.valid = upd && !ign_q && emit;
	assign launch.last  = last;
	assign launch.taps  = taps;

	// Frame counters and window registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			pos_q   <= '0;
			win_q   <= '0;
		end else begin
			state_q <= state_n;
			if (restart_req) begin
				col_q <= '0;
				row_q <= '0;
				pos_q <= '0;
				win_q <= '0;
			end else if (upd && !ign_q) begin
				if (((XW+1)'(x_q) + (XW+1)'(1)) >= (XW+1)'(eff_w)) begin
					col_q <= '0;
					row_q <= row_q + 12'd1;
				end else begin
					col_q <= x_q + CW'(1);
				end
				win_q <= win_n;
				if (emit) begin
					pos_q <= pos_q + TW'(1);
				end
				if (emit && last) begin
					col_q <= '0;
					row_q <= '0;
					pos_q <= '0;
					win_q <= '0;
				end
			end
		end
	end

endmodule

[rtl/rcf_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter: channel lane
// Filters one color channel: nine products, sum, scale, bias, clamp, round.
// ----------------------------------------------------------------------------
module rcf_lane (
	input  logic                                clk,
	input  logic                                en,
	input  logic [8:0][7:0]                     px,
	input  logic [8:0][rcf_pkg::COEF_BITS-1:0]  coefs,
	input  logic [23:0]                         scale,
	input  logic [16:0]                         bias,
	output logic [7:0]                          res
);
	import rcf_pkg::*;

	localparam int PW = COEF_BITS + 9;
	localparam int AW = COEF_BITS + 13;
	localparam int MW = AW + 25;

	logic signed [PW-1:0] prod_s1 [NUM_TAPS];
	logic signed [AW-1:0] acc_s2, acc_n;
	logic signed [MW-1:0] mul_s3;
	logic signed [MW:0]   t, bias_ext;
	logic        [MW:0]   rnd;
	logic        [7:0]    res_s4;

	localparam logic signed [MW:0] TOP_VAL = (MW+1)'(255) <<< 24;
	localparam logic signed [MW:0] HALF    = (MW+1)'(1) <<< 23;

	// Stage 1: coefficient times pixel for each tap.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_TAPS; i++) begin
				prod_s1[i] <= PW'($signed(coefs[i]) * $signed({1'b0, px[i]}));
			end
		end
	end

	// Stage 2: sum of the nine products.
	always_comb begin
		acc_n = '0;
		for (int i = 0; i < NUM_TAPS; i++) begin
			acc_n = acc_n + AW'(prod_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s2 <= acc_n;
		end
	end

	// Stage 3: multiply by the reciprocal scale.
	always_ff @(posedge clk) begin
		if (en) begin
			mul_s3 <= MW'(acc_s2 * $signed({1'b0, scale}));
		end
	end

	// Stage 4: add bias, clamp to the pixel range and round half up.
	assign bias_ext = $signed({{(MW-16){bias[16]}}, bias}) <<< 16;
	assign t        = (MW+1)'(mul_s3) + bias_ext;
	assign rnd      = unsigned'(t + HALF);

	always_ff @(posedge clk) begin
		if (en) begin
			if (t < 0) begin
				res_s4 <= 8'd0;
			end else if (t > TOP_VAL) begin
				res_s4 <= 8'd255;
			end else begin
				res_s4 <= rnd[31:24];
			end
		end
	end

	assign res = res_s4;

endmodule

[rtl/rgb_3x3_convolution_filter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter core
// Streams BGR pixels through two line stores and a 3x3 window and filters
// the three color channels in parallel lanes.
// ----------------------------------------------------------------------------
// Each input word passes through the window sequencer in a read step, which
// reads both line stores at the column, and an update step, which writes
// them back and shifts the window. A word that completes a window then runs
// through the three channel lanes (products, sum, scale, bias and clamp)
// into the output register. The next input word is taken only once the
// sequencer is back to idle and the lanes are empty, whether or not the last
// word made a result. A result waiting in the output register does
// not block the next input word. Results lag the input by one row and one
// pixel; flush words drain the frame tail, and frame_last marks the final
// result of a frame. The line stores are not cleared; rows above the frame
// read as zero. Writing the frame width or height restarts the frame.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_filter_core #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic   clk,
	input  logic   arst_n,
	rcf_pix_if.sink   pix,
	rcf_res_if.source res,
	rcf_cfg_if.sink   cfg
);
	import rcf_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int TW = XW + 12;

	logic [ROW_BITS-1:0]   kern_q [3];
	logic [SCALE_BITS-1:0] scale_q;
	logic [BIAS_BITS-1:0]  bias_q;
	logic [DIM_BITS-1:0]   fw_q, fh_q;
	logic                  cfg_wr, restart_req;

	logic [XW-1:0] eff_w;
	logic [11:0]   eff_h;
	logic [TW-1:0] total_q;

	logic    win_busy, accept, pipe_busy, adv, out_load;
	launch_t launch;
	logic    v_s1, v_s2, v_s3, v_s4;
	logic    l_s1, l_s2, l_s3, l_s4;

	logic [NUM_CH-1:0][8:0][7:0]  lane_px;
	logic [8:0][COEF_BITS-1:0]    coefs;
	logic [NUM_CH-1:0][7:0]       lane_res;

	logic       out_v_q, out_last_q;
	logic [7:0] out_b_q, out_g_q, out_r_q;

	// Configuration registers.
	assign cfg.ready   = 1'b1;
	assign cfg_wr      = cfg.valid && cfg.ready;
	assign restart_req = cfg_wr && ((cfg.index == REG_FRAME_WIDTH) ||
		(cfg.index == REG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_q[0] <= '0;
			kern_q[1] <= 48'h0000_0100_0000;
			kern_q[2] <= '0;
			scale_q   <= 24'd65536;
			bias_q    <= '0;
			fw_q      <= 12'd640;
			fh_q      <= 12'd480;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(cfg.index))
				REG_KERNEL_TOP:    kern_q[0] <= cfg.data;
				REG_KERNEL_MIDDLE: kern_q[1] <= cfg.data;
				REG_KERNEL_BOTTOM: kern_q[2] <= cfg.data;
				REG_SCALE:         scale_q   <= cfg.data[SCALE_BITS-1:0];
				REG_BIAS:          bias_q    <= cfg.data[BIAS_BITS-1:0];
				REG_FRAME_WIDTH:   fw_q      <= cfg.data[DIM_BITS-1:0];
				REG_FRAME_HEIGHT:  fh_q      <= cfg.data[DIM_BITS-1:0];
				default:           ;
			endcase
		end
	end

	// Effective frame size: zero acts as one, large values are capped.
	always_comb begin
		if (fw_q == '0) begin
			eff_w = XW'(1);
		end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
			eff_w = XW'(MAX_WIDTH);
		end else begin
			eff_w = XW'(fw_q);
		end
		if (fh_q == '0) begin
			eff_h = 12'd1;
		end else if (32'(fh_q) > 32'(HEIGHT_CAP)) begin
			eff_h = 12'(HEIGHT_CAP);
		end else begin
			eff_h = fh_q;
		end
	end

	// Pixels per frame, registered off the configuration.
	always_ff @(posedge clk) begin
		total_q <= TW'(eff_w * eff_h);
	end

	// Input handshake: one word at a time through window and lanes.
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign pix.ready = !win_busy && !pipe_busy;
	assign accept    = pix.valid && pix.ready;

	rcf_window #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.is_flush   (pix.is_flush),
		.pixel      ({pix.pixel_red, pix.pixel_green, pix.pixel_blue}),
		.restart_req(restart_req),
		.eff_w      (eff_w),
		.eff_h      (eff_h),
		.total      (total_q),
		.busy       (win_busy),
		.launch     (launch)
	);

	// Split the window per channel and the kernel per tap.
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			for (int i = 0; i < NUM_TAPS; i++) begin
				lane_px[ch][i] = launch.taps[i][ch*CH_BITS +: CH_BITS];
			end
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				coefs[r*3+c] = kern_q[r][(2 - c) * COEF_BITS +: COEF_BITS];
			end
		end
	end

	// Lane pipeline stalls only when a result is blocked at the output.
	assign out_load = v_s4 && (!out_v_q || res.ready);
	assign adv      = !v_s4 || out_load;

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
		rcf_lane u_lane (
			.clk  (clk),
			.en   (adv),
			.px   (lane_px[ch]),
			.coefs(coefs),
			.scale(scale_q),
			.bias (bias_q),
			.res  (lane_res[ch])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= launch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s1 <= launch.last;
			l_s2 <= l_s1;
			l_s3 <= l_s2;
			l_s4 <= l_s3;
		end
	end

	// Merge the three lanes into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_b_q    <= lane_res[0];
			out_g_q    <= lane_res[1];
			out_r_q    <= lane_res[2];
			out_last_q <= l_s4;
		end
	end

	assign res.valid      = out_v_q;
	assign res.out_blue   = out_b_q;
	assign res.out_green  = out_g_q;
	assign res.out_red    = out_r_q;
	assign res.frame_last = out_last_q;

endmodule

[rtl/rcf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter: port checker
// Watches the top-level channels and flags sequencing slips.
// ----------------------------------------------------------------------------
module rcf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_valid,
	input logic       pix_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] res_blue,
	input logic [7:0] res_green,
	input logic [7:0] res_red,
	input logic       res_last
);

	// A result word held back keeps its value.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid &&
		$stable(res_blue) && $stable(res_green) && $stable(res_red) && $stable(res_last))
		else $error("result word changed while stalled");

	// Each accepted word keeps the sequencer busy, so input is not taken twice in a row.
	a_seq_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> !pix_ready)
		else $error("input taken twice in a row");

	// A new result only appears after the lanes were busy.
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(pix_ready))
		else $error("result appeared while input side was idle");

endmodule

bind rgb_3x3_convolution_filter_core rcf_checker u_rcf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pix_valid(pix.valid),
	.pix_ready(pix.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_blue (res.out_blue),
	.res_green(res.out_green),
	.res_red  (res.out_red),
	.res_last (res.frame_last)
);

[sim/tb_rgb_3x3_convolution_filter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the RGB 3x3 convolution filter core
// Streams frames of BGR pixels through the core under many kernel, scale,
// bias and frame size settings. A behavioral predictor in the bench keeps
// its own line stores and window and queues the expected filtered pixels.
// A checker compares every output word against the oldest expectation.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_rgb_3x3_convolution_filter_core;
	import rcf_pkg::*;

	localparam logic [IDX_BITS-1:0] IDX_UNUSED = 3'd7;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_MISMATCH_PRINTS = 10;

	typedef struct {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last;
	} filtered_pixel_t;

	logic clk;
	logic arst_n;

	rcf_pix_if pix ();
	rcf_res_if res ();
	rcf_cfg_if cfg ();

	rgb_3x3_convolution_filter_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	// Clock: 20 ns period.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Predictor state: registers, line stores, window and counters.
	logic [ROW_BITS-1:0]   kernel_row [3];
	logic [SCALE_BITS-1:0] scale_reg;
	logic [BIAS_BITS-1:0]  bias_reg;
	logic [DIM_BITS-1:0]   width_reg;
	logic [DIM_BITS-1:0]   height_reg;
	pixel_t                upper_store [2048];
	pixel_t                lower_store [2048];
	pixel_t                window [NUM_TAPS];
	int unsigned           col_pos;
	int unsigned           row_pos;
	int unsigned           out_count;
	bit                    frame_done;

	filtered_pixel_t expected_pixels [$];
	int  mismatches;
	int  results_checked;
	int  frames_done;
	int  flushes_ignored;
	int  pixels_sent;
	int  burst_left;

	function automatic int unsigned active_width();
		int unsigned w;
		w = width_reg;
		if (w == 0) w = 1;
		if (w > 2048) w = 2048;
		return w;
	endfunction

	function automatic int unsigned active_height();
		int unsigned h;
		h = height_reg;
		if (h == 0) h = 1;
		if (h > HEIGHT_CAP) h = HEIGHT_CAP;
		return h;
	endfunction

	function automatic void restart_frame();
		col_pos = 0;
		row_pos = 0;
		out_count = 0;
		for (int i = 0; i < NUM_TAPS; i++) window[i] = '0;
	endfunction

	// One channel of the filter: convolve, scale, add bias, clamp and round.
	function automatic logic [7:0] convolve_channel(input pixel_t taps [NUM_TAPS], input int ch);
		longint acc;
		longint t;
		longint sc;
		longint px;
		longint k;
		logic signed [15:0] coef;
		logic signed [BIAS_BITS-1:0] b;
		acc = 0;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				coef = kernel_row[r][(2-c)*16 +: 16];
				k = coef;
				px = taps[r*3+c][ch*8 +: 8];
				acc += k * px;
			end
		sc = scale_reg;
		b = bias_reg;
		t = acc * sc + longint'(b) * 65536;
		if (t < 0) t = 0;
		if (t > (longint'(255) <<< 24)) t = longint'(255) <<< 24;
		t = (t + (longint'(1) <<< 23)) >>> 24;
		return t[7:0];
	endfunction

	// Advance the predictor by one accepted input word.
	function automatic void predict_word(input logic flush, input pixel_t px);
		int unsigned w, h, x, y;
		bit tail, emit;
		pixel_t bot, mid, top;
		pixel_t taps [NUM_TAPS];
		filtered_pixel_t fp;
		w = active_width();
		h = active_height();
		x = col_pos;
		y = row_pos;
		tail = (y >= h);
		emit = 0;
		if (!tail && flush) begin
			flushes_ignored++;
			return;
		end
		pixels_sent++;
		if (x >= w) x = 0;
		bot = tail ? '0 : px;
		mid = (y >= 1) ? lower_store[x] : '0;
		top = (y >= 2) ? upper_store[x] : '0;
		upper_store[x] = mid;
		lower_store[x] = bot;
		if (x == 0) begin
			// The previous row ends here with an empty right column.
			if (y >= 2) begin
				for (int i = 0; i < 3; i++) begin
					taps[i*3]   = window[i*3+1];
					taps[i*3+1] = window[i*3+2];
					taps[i*3+2] = '0;
				end
				emit = 1;
			end
			for (int i = 0; i < 3; i++) begin
				window[i*3]   = '0;
				window[i*3+1] = '0;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				window[i*3]   = window[i*3+1];
				window[i*3+1] = window[i*3+2];
			end
			if (y >= 1) emit = 1;
		end
		window[2] = top;
		window[5] = mid;
		window[8] = bot;
		if (emit && x != 0) taps = window;
		if (x + 1 >= w) begin
			col_pos = 0;
			row_pos = y + 1;
		end else begin
			col_pos = x + 1;
			row_pos = y;
		end
		if (!emit) return;
		fp.blue  = convolve_channel(taps, 0);
		fp.green = convolve_channel(taps, 1);
		fp.red   = convolve_channel(taps, 2);
		fp.last  = (out_count + 1 >= w * h);
		expected_pixels.push_back(fp);
		out_count = (out_count + 1) & 32'h3FFFFF;
		if (fp.last) begin
			restart_frame();
			frame_done = 1;
			frames_done++;
		end
	endfunction

	function automatic void predict_write(input logic [IDX_BITS-1:0] idx, input logic [47:0] data);
		case (idx)
			REG_KERNEL_TOP:    kernel_row[0] = data;
			REG_KERNEL_MIDDLE: kernel_row[1] = data;
			REG_KERNEL_BOTTOM: kernel_row[2] = data;
			REG_SCALE:         scale_reg = data[SCALE_BITS-1:0];
			REG_BIAS:          bias_reg = data[BIAS_BITS-1:0];
			REG_FRAME_WIDTH: begin
				width_reg = data[DIM_BITS-1:0];
				restart_frame();
			end
			REG_FRAME_HEIGHT: begin
				height_reg = data[DIM_BITS-1:0];
				restart_frame();
			end
			default: ;
		endcase
	endfunction

	// Result checker: compare each accepted output word with the oldest expectation.
	always @(posedge clk) begin
		filtered_pixel_t want;
		if (arst_n && res.valid && res.ready) begin
			results_checked++;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_MISMATCH_PRINTS)
					$display("%t: unexpected output word b=%0d g=%0d r=%0d last=%0b", $realtime,
						res.out_blue, res.out_green, res.out_red, res.frame_last);
			end else begin
				want = expected_pixels.pop_front();
				if (res.out_blue !== want.blue || res.out_green !== want.green ||
						res.out_red !== want.red || res.frame_last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_MISMATCH_PRINTS)
						$display("%t: mismatch: expected b=%0d g=%0d r=%0d last=%0b, got b=%0d g=%0d r=%0d last=%0b",
							$realtime, want.blue, want.green, want.red, want.last,
							res.out_blue, res.out_green, res.out_red, res.frame_last);
				end
			end
		end
	end

	// Output back-pressure: one of four stall patterns, picked anew at random.
	int unsigned stall_cycle;
	int unsigned stall_mode;
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1;
		if (stall_cycle % 97 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: res.ready <= 1'b1;
			1: res.ready <= ($urandom_range(0, 9) < 6);
			2: res.ready <= (stall_cycle % 8 == 0);
			default: res.ready <= ($urandom_range(0, 9) < 9);
		endcase
	end

	// Send one input word; the sender runs in bursts with random gaps between them.
	task automatic send_word(input logic flush, input pixel_t px);
		int gap;
		pix.valid       <= 1'b1;
		pix.is_flush    <= flush;
		pix.pixel_blue  <= px[7:0];
		pix.pixel_green <= px[15:8];
		pix.pixel_red   <= px[23:16];
		do @(posedge clk); while (!pix.ready);
		predict_word(flush, px);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
		end
	endtask

	// Stop sending and wait until every expected word has come out.
	task automatic wait_idle();
		pix.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write; the caller lowers valid with end_writes.
	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [47:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		predict_write(idx, data);
	endtask

	task automatic end_writes();
		cfg.valid <= 1'b0;
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		end_writes();
	endtask

	task automatic set_filter(input logic [47:0] k0, input logic [47:0] k1, input logic [47:0] k2,
			input logic [23:0] sc, input logic [16:0] b);
		wait_idle();
		write_reg(REG_KERNEL_TOP, k0);
		write_reg(REG_KERNEL_MIDDLE, k1);
		write_reg(REG_KERNEL_BOTTOM, k2);
		write_reg(REG_SCALE, sc);
		write_reg(REG_BIAS, {{31{b[16]}}, b});
		end_writes();
	endtask

	function automatic pixel_t random_pixel();
		return pixel_t'($urandom);
	endfunction

	// Feed a whole frame, with ignored flush words mixed in, then drain its tail.
	task automatic run_frame(input int noise_pct, input int pixel_drain_pct);
		int unsigned n;
		n = active_width() * active_height();
		frame_done = 0;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < noise_pct) send_word(1'b1, random_pixel());
			send_word(1'b0, random_pixel());
		end
		while (!frame_done)
			send_word($urandom_range(0, 99) >= pixel_drain_pct, random_pixel());
	endtask

	function automatic logic [47:0] small_kernel_row();
		logic [15:0] c [3];
		for (int i = 0; i < 3; i++) c[i] = 16'($signed($urandom_range(0, 1024)) - 512);
		return {c[0], c[1], c[2]};
	endfunction

	// Identity kernel at reset values, pixels at both extremes.
	task automatic test_identity_extremes();
		pixel_t vals [4];
		set_frame(4, 3);
		vals = '{24'h000000, 24'hFFFFFF, 24'hFF00FF, 24'h00FF00};
		frame_done = 0;
		for (int i = 0; i < 12; i++) begin
			if (i == 5) send_word(1'b1, 24'hFFFFFF);
			send_word(1'b0, vals[i % 4]);
		end
		// Pixel words after the frame act as flush words.
		while (!frame_done) send_word(1'b0, 24'hFFFFFF);
	endtask

	// Kernel, scale and bias at their limits on tiny frames.
	task automatic test_arith_limits();
		set_filter({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 24'hFFFFFF, 17'h0FFFF);
		set_frame(3, 3);
		run_frame(0, 0);
		set_filter({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 24'hFFFFFF, 17'h10000);
		run_frame(0, 50);
		// Scale of zero leaves only the clamped bias.
		set_filter({3{16'h0100}}, {3{16'h0100}}, {3{16'h0100}}, 24'h0, 17'h00780);
		run_frame(0, 0);
		// Box blur with a divisor of nine and a half-step bias.
		set_filter({3{16'h0100}}, {3{16'h0100}}, {3{16'h0100}}, 24'd7282, 17'h00080);
		run_frame(10, 20);
	endtask

	// Degenerate frame dimensions, sizes wider than the register and an unused index.
	task automatic test_frame_sizes();
		set_frame(0, 0);
		wait_idle();
		write_reg(IDX_UNUSED, 48'hFFFF_FFFF_FFFF);
		end_writes();
		run_frame(50, 0);
		set_frame(1, 1);
		run_frame(0, 100);
		// Only the low twelve bits are kept: these act as a 1 x 3 frame.
		set_frame(4096, 4099);
		run_frame(0, 0);
		set_frame(3, 1);
		run_frame(0, 0);
	endtask

	// A frame cut short by a width write restarts cleanly.
	task automatic test_restart();
		set_frame(5, 4);
		frame_done = 0;
		for (int i = 0; i < 13; i++) send_word(1'b0, random_pixel());
		set_frame(5, 4);
		run_frame(5, 30);
		set_frame(3, 2);
		for (int i = 0; i < 4; i++) send_word(1'b0, random_pixel());
		wait_idle();
		write_reg(REG_FRAME_HEIGHT, 2);
		end_writes();
		run_frame(0, 0);
	endtask

	// Random frames with random settings until enough words have gone in.
	task automatic test_random_frames(input int target);
		int start;
		start = pixels_sent;
		while (pixels_sent - start < target) begin
			if ($urandom_range(0, 1))
				set_filter(small_kernel_row(), small_kernel_row(), small_kernel_row(),
					24'(65536 / $urandom_range(1, 16)), 17'($signed($urandom_range(0, 512)) - 256));
			else if ($urandom_range(0, 2) == 0)
				set_filter({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					24'($urandom), 17'($urandom));
			if ($urandom_range(0, 9) == 0)
				set_frame($urandom_range(0, 2), $urandom_range(0, 3));
			else
				set_frame($urandom_range(1, 10), $urandom_range(1, 6));
			if ($urandom_range(0, 7) == 0) begin
				// Broken frame: stop part way and start over.
				for (int i = $urandom_range(1, 20); i > 0; i--) send_word(1'b0, random_pixel());
				set_frame(active_width(), active_height());
			end
			run_frame($urandom_range(0, 8), $urandom_range(0, 50));
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		pix.valid       = 1'b0;
		pix.is_flush    = 1'b0;
		pix.pixel_blue  = '0;
		pix.pixel_green = '0;
		pix.pixel_red   = '0;
		cfg.valid       = 1'b0;
		cfg.index       = '0;
		cfg.data        = '0;
		res.ready       = 1'b1;
		stall_cycle     = 0;
		stall_mode      = 0;
		mismatches      = 0;
		results_checked = 0;
		frames_done     = 0;
		flushes_ignored = 0;
		pixels_sent     = 0;
		burst_left      = 0;
		kernel_row[0]   = '0;
		kernel_row[1]   = 48'h000001000000;
		kernel_row[2]   = '0;
		scale_reg       = 24'd65536;
		bias_reg        = '0;
		width_reg       = 12'd640;
		height_reg      = 12'd480;
		restart_frame();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity_extremes();
		test_arith_limits();
		test_restart();
		test_frame_sizes();
		test_random_frames(1500);
		wait_idle();

		$display("Checked %0d output words over %0d frames; %0d words sent, %0d early flushes ignored.",
			results_checked, frames_done, pixels_sent, flushes_ignored);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("** rgb_3x3_convolution_filter_core: PASSED **");
		else
			$display("** rgb_3x3_convolution_filter_core: FAILED **");
		$finish;
	end

	// Watchdog.
	initial begin
		#50ms;
		$display("Timeout with %0d words still expected.", expected_pixels.size());
		$display("** rgb_3x3_convolution_filter_core: FAILED **");
		$finish;
	end

endmodule

[sim.f]
rtl/rcf_pkg.sv
rtl/rcf_if.sv
rtl/rcf_window.sv
rtl/rcf_lane.sv
rtl/rgb_3x3_convolution_filter_core.sv
rtl/rcf_checker.sv
sim/tb_rgb_3x3_convolution_filter_core.sv
